[src/alpe_pkg.sv]
// Shared types and constants for the addressable LED pixel encoder.
`timescale 1ns / 1ps

package alpe_pkg;

	localparam int WHEEL_STEPS_DEF = 84;
	localparam int BITS_PER_PIXEL  = 24;
	localparam int BIT_IDX_W       = 5;
	localparam int CFG_IDX_W       = 2;

	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_PIXEL - 1);

	localparam logic [7:0] ZERO_CODE_RST = 8'h30;
	localparam logic [7:0] ONE_CODE_RST  = 8'h3c;
	localparam logic [7:0] FULL_SCALE    = 8'hff;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE  = CFG_IDX_W'(1);

	// Wheel segment of a position.
	typedef enum logic [1:0] {
		SEG_RB = 2'd0, // red falls, blue rises
		SEG_GB = 2'd1, // green rises, blue falls
		SEG_RG = 2'd2  // red rises, green falls
	} seg_t;

	// One scaled pixel handed to the serializer.
	typedef struct packed {
		logic [23:0] grb;
		logic [7:0]  idx;
	} pix_t;

endpackage

[src/alpe_color_pipe.sv]
// Four-stage colour pipeline: wheel wrap, ramp multiply, colour pick, brightness scale.
`timescale 1ns / 1ps

module alpe_color_pipe #(
	parameter int WHEEL_STEPS = alpe_pkg::WHEEL_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          mode,
	input  logic [23:0]   color,
	input  logic [7:0]    wheel_pos,
	input  logic [7:0]    brightness,
	input  logic [7:0]    pixel_index,
	output logic          out_valid,
	input  logic          out_ready,
	output alpe_pkg::pix_t out_pix
);
	import alpe_pkg::*;

	localparam int SEG   = WHEEL_STEPS / 3;
	localparam int SLOPE = 255 / SEG;
	localparam logic [7:0] STEPS8 = 8'(WHEEL_STEPS);
	localparam logic [7:0] SEG8   = 8'(SEG);
	localparam logic [7:0] SEG2X8 = 8'(2 * SEG);
	localparam logic [7:0] SLOPE8 = 8'(SLOPE);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: wrap the position once, saturate, and mirror it.
	logic [7:0] pos_wrap, pos_sat;
	always_comb begin
		pos_wrap = (wheel_pos >= STEPS8) ? wheel_pos - STEPS8 : wheel_pos;
		pos_sat  = (pos_wrap >= STEPS8) ? STEPS8 - 8'd1 : pos_wrap;
	end

	logic        mode_s1;
	logic [23:0] color_s1;
	logic [7:0]  bright_s1, pix_s1, w_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mode_s1   <= mode;
			color_s1  <= color;
			bright_s1 <= brightness;
			pix_s1    <= pixel_index;
			w_s1      <= (STEPS8 - 8'd1) - pos_sat;
		end
	end

	// Stage 2: pick the segment and multiply the offset by the slope.
	seg_t       seg_c;
	logic [7:0] off_c;
	always_comb begin
		if (w_s1 < SEG8) begin
			seg_c = SEG_RB;
			off_c = w_s1;
		end else if (w_s1 < SEG2X8) begin
			seg_c = SEG_GB;
			off_c = w_s1 - SEG8;
		end else begin
			seg_c = SEG_RG;
			off_c = w_s1 - SEG2X8;
		end
	end

	logic        mode_s2;
	logic [23:0] color_s2;
	logic [7:0]  bright_s2, pix_s2;
	seg_t        seg_s2;
	logic [15:0] ramp_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			mode_s2   <= mode_s1;
			color_s2  <= color_s1;
			bright_s2 <= bright_s1;
			pix_s2    <= pix_s1;
			seg_s2    <= seg_c;
			ramp_s2   <= 16'(off_c) * 16'(SLOPE8);
		end
	end

	// Stage 3: saturate the ramp and build the colour.
	logic [7:0]  up_c, down_c;
	logic [23:0] wheel_rgb, rgb_c;
	always_comb begin
		up_c   = (ramp_s2 > 16'(FULL_SCALE)) ? FULL_SCALE : ramp_s2[7:0];
		down_c = FULL_SCALE - up_c;
		unique case (seg_s2)
			SEG_RB:  wheel_rgb = {down_c, 8'd0, up_c};
			SEG_GB:  wheel_rgb = {8'd0, up_c, down_c};
			SEG_RG:  wheel_rgb = {up_c, down_c, 8'd0};
			default: wheel_rgb = 24'd0;
		endcase
		rgb_c = mode_s2 ? wheel_rgb : color_s2;
	end

	logic [23:0] rgb_s3;
	logic [8:0]  scale_s3;
	logic [7:0]  pix_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			rgb_s3   <= rgb_c;
			scale_s3 <= {1'b0, bright_s2} + 9'd1;
			pix_s3   <= pix_s2;
		end
	end

	// Stage 4: scale each channel by the brightness.
	logic [16:0] r_s4, g_s4, b_s4;
	logic [7:0]  pix_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			r_s4   <= 17'(rgb_s3[23:16]) * 17'(scale_s3);
			g_s4   <= 17'(rgb_s3[15:8]) * 17'(scale_s3);
			b_s4   <= 17'(rgb_s3[7:0]) * 17'(scale_s3);
			pix_s4 <= pix_s3;
		end
	end

	assign out_valid   = v_s4;
	assign out_pix.grb = {g_s4[15:8], r_s4[15:8], b_s4[15:8]};
	assign out_pix.idx = pix_s4;

endmodule

[src/addressable_led_pixel_encoder.sv]
// Top level of the addressable LED pixel encoder: colour pipeline, SPI bit serializer, registers.
`timescale 1ns / 1ps

// A pixel request (start while busy is low) carries either a packed RGB colour (mode 0)
// or a colour wheel position (mode 1), a brightness and the LED's strip index. The
// colour is scaled, reordered to GRB and sent MSB first as 24 SPI code bytes, one per
// clock cycle, each on the output ports for exactly one cycle with strobe high; the
// receiver cannot hold them off. The serializer emits one byte per cycle and loads the
// next pixel during the last byte of the current one, so back-to-back requests run
// with no gap between pixels. A request passes the four-stage colour pipeline before
// the serializer loads it. Up to four further requests are taken while a pixel is
// being sent; busy rises once the pipeline is full. The zero and one codes are written
// over the cfg port (index 0 zero code, index 1 one code; other indexes are dropped)
// and should only be changed while no pixel is in flight.
module addressable_led_pixel_encoder #(
	parameter int WHEEL_STEPS = alpe_pkg::WHEEL_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           mode,
	input  logic [23:0]                    color,
	input  logic [7:0]                     wheel_pos,
	input  logic [7:0]                     brightness,
	input  logic [7:0]                     pixel_index,
	output logic                           strobe,
	output logic [7:0]                     spi_byte,
	output logic [7:0]                     pixel_index_out,
	output logic [alpe_pkg::BIT_IDX_W-1:0] bit_index,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [alpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import alpe_pkg::*;

	// Code registers; always ready for a write request.
	logic [7:0] zero_code_q, one_code_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_code_q <= ZERO_CODE_RST;
			one_code_q  <= ONE_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ZERO_CODE) zero_code_q <= cfg_data;
			if (cfg_index == CFG_ONE_CODE)  one_code_q  <= cfg_data;
		end
	end

	// Colour pipeline.
	logic  in_ready;
	logic  pipe_valid, pipe_ready;
	pix_t  pipe_pix;

	assign busy = !in_ready;

	alpe_color_pipe #(
		.WHEEL_STEPS (WHEEL_STEPS)
	) u_color_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.in_ready    (in_ready),
		.mode        (mode),
		.color       (color),
		.wheel_pos   (wheel_pos),
		.brightness  (brightness),
		.pixel_index (pixel_index),
		.out_valid   (pipe_valid),
		.out_ready   (pipe_ready),
		.out_pix     (pipe_pix)
	);

	// Serializer: hold the GRB word, shift out one bit per cycle.
	logic                 act_q;
	logic [BIT_IDX_W-1:0] cnt_q;
	logic [23:0]          grb_q;
	logic [7:0]           pix_q;
	logic                 at_last;
	logic                 load;

	assign at_last    = (cnt_q == LAST_BIT);
	// Take the next pixel when idle or during the last byte of the current one.
	assign pipe_ready = !act_q || at_last;
	assign load       = pipe_valid && pipe_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			if (at_last) begin
				act_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + BIT_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grb_q <= pipe_pix.grb;
			pix_q <= pipe_pix.idx;
		end else if (act_q) begin
			grb_q <= {grb_q[22:0], 1'b0};
		end
	end

	// Drive the current byte straight from the serializer registers.
	assign strobe          = act_q;
	assign spi_byte        = grb_q[23] ? one_code_q : zero_code_q;
	assign pixel_index_out = pix_q;
	assign bit_index       = cnt_q;
	assign last            = act_q && at_last;

	// Within a pixel the bytes are consecutive with rising bit numbers.
	a_bit_advance: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && bit_index == $past(bit_index) + BIT_IDX_W'(1))
		else $error("bit index did not advance within a pixel");

	// The pixel index holds across the bytes of one pixel.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> $stable(pixel_index_out))
		else $error("pixel index changed inside a pixel");

	// A pixel always starts at the green MSB.
	a_first_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(!strobe || last) |=> !strobe || bit_index == '0)
		else $error("pixel did not start at bit zero");

endmodule

[bench/addressable_led_pixel_encoder_tb.sv]
// Self-checking testbench for the addressable LED pixel encoder: directed and random pixels.
`timescale 1ns / 1ps

module addressable_led_pixel_encoder_tb;

	import alpe_pkg::*;

	localparam int WHEEL_STEPS = WHEEL_STEPS_DEF;

	// Give up after this many cycles with no request, no code byte and no register write.
	localparam int STALL_LIMIT = 1000;
	// Cycles to let pass once every code byte has arrived: pipeline depth plus margin.
	localparam int SETTLE_CYCLES = 10;

	// Register indexes past the end of the register list; writes there are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

	// One SPI code byte as it should leave the block.
	typedef struct packed {
		logic [7:0]           code;
		logic [7:0]           pix;
		logic [BIT_IDX_W-1:0] bit_no;
		logic                 is_last;
	} spi_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 mode = 1'b0;
	logic [23:0]          color = '0;
	logic [7:0]           wheel_pos = '0;
	logic [7:0]           brightness = '0;
	logic [7:0]           pixel_index = '0;
	logic                 strobe;
	logic [7:0]           spi_byte;
	logic [7:0]           pixel_index_out;
	logic [BIT_IDX_W-1:0] bit_index;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	// Predictor copy of the code registers, updated when a write is accepted.
	logic [7:0] zero_pattern = ZERO_CODE_RST;
	logic [7:0] one_pattern  = ONE_CODE_RST;

	// Code bytes still owed by the block, oldest first.
	spi_beat_t pending_bytes[$];

	int mismatches = 0;
	int stall_cycles = 0;

	addressable_led_pixel_encoder #(
		.WHEEL_STEPS(WHEEL_STEPS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.color(color),
		.wheel_pos(wheel_pos),
		.brightness(brightness),
		.pixel_index(pixel_index),
		.strobe(strobe),
		.spi_byte(spi_byte),
		.pixel_index_out(pixel_index_out),
		.bit_index(bit_index),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Map a wheel position to packed RGB. Wrap once by the wheel size, then clamp
	// whatever is still out of range to the last step. The ramp saturates at full
	// scale so the falling channel floors at zero when the size is not a multiple of 3.
	function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
		int unsigned p, w, third, slope, up;
		seg_t seg;
		third = WHEEL_STEPS / 3;
		slope = (third != 0) ? 255 / third : 255;
		p = 32'(pos);
		if (p >= WHEEL_STEPS) p -= WHEEL_STEPS;
		if (p >= WHEEL_STEPS) p = WHEEL_STEPS - 1;
		w = WHEEL_STEPS - 1 - p;
		if (w < third) begin
			seg = SEG_RB;
		end else if (w < 2 * third) begin
			seg = SEG_GB;
			w -= third;
		end else begin
			seg = SEG_RG;
			w -= 2 * third;
		end
		up = (w * slope > 255) ? 255 : w * slope;
		case (seg)
			SEG_RB:  return {8'(255 - up), 8'h00, 8'(up)};
			SEG_GB:  return {8'h00, 8'(up), 8'(255 - up)};
			default: return {8'(up), 8'(255 - up), 8'h00};
		endcase
	endfunction

	// Scale one channel by (brightness + 1) / 256, truncating.
	function automatic logic [7:0] dim(input logic [7:0] ch, input logic [7:0] br);
		logic [16:0] prod;
		prod = 17'(ch) * (17'(br) + 17'd1);
		return prod[15:8];
	endfunction

	// Work out the 24 code bytes of one accepted request and queue them, green MSB first.
	task automatic queue_pixel_bytes(input logic m, input logic [23:0] c,
			input logic [7:0] wp, input logic [7:0] br, input logic [7:0] pix);
		logic [23:0] rgb, grb;
		spi_beat_t beat;
		rgb = m ? wheel_rgb(wp) : c;
		grb = {dim(rgb[15:8], br), dim(rgb[23:16], br), dim(rgb[7:0], br)};
		for (int i = 0; i < BITS_PER_PIXEL; i++) begin
			beat.code    = grb[23 - i] ? one_pattern : zero_pattern;
			beat.pix     = pix;
			beat.bit_no  = BIT_IDX_W'(i);
			beat.is_last = (i == BITS_PER_PIXEL - 1);
			pending_bytes.push_back(beat);
		end
	endtask

	// Present one pixel request and hold it until the block takes it. Leave start
	// high so a following request can go out back to back.
	task automatic send_pixel(input logic m, input logic [23:0] c, input logic [7:0] wp,
			input logic [7:0] br, input logic [7:0] pix);
		start       <= 1'b1;
		mode        <= m;
		color       <= c;
		wheel_pos   <= wp;
		brightness  <= br;
		pixel_index <= pix;
		do @(posedge clk); while (busy);
		queue_pixel_bytes(m, c, wp, br, pix);
	endtask

	// Drop start for a random pause, about once in odds requests.
	// Zero odds means no idling at all.
	task automatic maybe_pause(input int odds);
		if (odds != 0 && $urandom_range(1, odds) == 1) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Drop start and wait until every owed byte is out, then let the pipeline settle.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one code register; mirror the write in the predictor once it is taken.
	task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ZERO_CODE: zero_pattern = data;
			CFG_ONE_CODE:  one_pattern = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// Compare every code byte against the oldest expectation, field by field.
	always @(posedge clk) begin
		spi_beat_t want;
		if (arst_n && strobe) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected byte expected none actual %h", $time, spi_byte);
			end else begin
				want = pending_bytes.pop_front();
				report_field("spi_byte", 32'(want.code), 32'(spi_byte));
				report_field("pixel_index_out", 32'(want.pix), 32'(pixel_index_out));
				report_field("bit_index", 32'(want.bit_no), 32'(bit_index));
				report_field("last", 32'(want.is_last), 32'(last));
			end
		end
	end

	// Count cycles in which nothing moves on any channel.
	always @(posedge clk) begin
		if ((start && !busy) || (arst_n && strobe) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("addressable_led_pixel_encoder verification failed");
		$finish;
	end

	// Reset codes: black, white, brightness extremes, strip index extremes.
	task automatic test_reset_codes();
		send_pixel(1'b0, 24'h000000, 8'd0, 8'd255, 8'd0);
		send_pixel(1'b0, 24'hffffff, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b0, 24'hffffff, 8'd0, 8'd0, 8'd1);
	endtask

	// Packed colors: walk single bits through each channel, check the GRB reorder
	// and the truncation at the edges of the brightness range.
	task automatic test_packed_colors();
		send_pixel(1'b0, 24'h800001, 8'h5a, 8'd255, 8'h80);
		send_pixel(1'b0, 24'h018000, 8'ha5, 8'd255, 8'h7f);
		send_pixel(1'b0, 24'h000180, 8'h00, 8'd254, 8'h55);
		send_pixel(1'b0, 24'haa55aa, 8'hff, 8'd127, 8'haa);
		send_pixel(1'b0, 24'h0f0f0f, 8'h01, 8'd1, 8'h0f);
	endtask

	// Wheel: segment boundaries, the single wrap, the clamp past two wheel sizes,
	// and a noisy color field that must be ignored.
	task automatic test_wheel();
		send_pixel(1'b1, 24'hffffff, 8'd0, 8'd255, 8'd10);
		send_pixel(1'b1, 24'h123456, 8'(WHEEL_STEPS / 3 - 1), 8'd255, 8'd11);
		send_pixel(1'b1, 24'h000000, 8'(WHEEL_STEPS / 3), 8'd255, 8'd12);
		send_pixel(1'b1, 24'hfedcba, 8'(2 * WHEEL_STEPS / 3 - 1), 8'd255, 8'd13);
		send_pixel(1'b1, 24'h00ff00, 8'(2 * WHEEL_STEPS / 3), 8'd200, 8'd14);
		send_pixel(1'b1, 24'h0000ff, 8'(WHEEL_STEPS - 1), 8'd255, 8'd15);
		send_pixel(1'b1, 24'hff0000, 8'(WHEEL_STEPS), 8'd255, 8'd16);
		send_pixel(1'b1, 24'h5a5a5a, 8'(2 * WHEEL_STEPS - 1), 8'd255, 8'd17);
		send_pixel(1'b1, 24'ha5a5a5, 8'(2 * WHEEL_STEPS), 8'd255, 8'd18);
		send_pixel(1'b1, 24'hffffff, 8'd255, 8'd255, 8'd19);
		send_pixel(1'b1, 24'h000000, 8'd166, 8'd0, 8'd20);
	endtask

	// Code registers: extreme patterns both ways round, then writes to spare
	// indexes that must leave the codes alone.
	task automatic test_code_registers();
		wait_idle();
		write_code(CFG_ZERO_CODE, 8'h00);
		write_code(CFG_ONE_CODE, 8'hff);
		send_pixel(1'b0, 24'hc3a55a, 8'd0, 8'd255, 8'd30);
		wait_idle();
		write_code(CFG_ZERO_CODE, 8'hff);
		write_code(CFG_ONE_CODE, 8'h00);
		send_pixel(1'b0, 24'h3c5aa5, 8'd0, 8'd255, 8'd31);
		wait_idle();
		write_code(CFG_SPARE_LO, 8'h12);
		write_code(CFG_SPARE_HI, 8'hed);
		send_pixel(1'b1, 24'h000000, 8'd40, 8'd255, 8'd32);
		send_pixel(1'b0, 24'hf0f00f, 8'd0, 8'd255, 8'd33);
	endtask

	// Random traffic in phases, each with fresh codes and a chosen idling rate.
	// The middle phase and the last one run without any idling.
	task automatic test_random_traffic();
		int odds;
		logic [7:0] br;
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			write_code(CFG_ZERO_CODE, 8'($urandom));
			write_code(CFG_ONE_CODE, 8'($urandom));
			if (phase == 3)
				write_code($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
			case (phase)
				0:       odds = 2;
				1:       odds = 5;
				3:       odds = 3;
				default: odds = 0;
			endcase
			for (int n = 0; n < 50; n++) begin
				case ($urandom_range(0, 7))
					0:       br = 8'd0;
					1:       br = 8'd255;
					default: br = 8'($urandom);
				endcase
				send_pixel(1'($urandom_range(0, 1)), 24'($urandom),
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 166)),
					br, 8'($urandom));
				maybe_pause(odds);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_codes();
		test_packed_colors();
		test_wheel();
		test_code_registers();
		test_random_traffic();

		// Drain the last pixels; anything still owed afterwards is a failure.
		wait_idle();
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("addressable_led_pixel_encoder verification clean");
		else
			$display("addressable_led_pixel_encoder verification failed");
		$finish;
	end

endmodule

[filelist.f]
src/alpe_pkg.sv
src/alpe_color_pipe.sv
src/addressable_led_pixel_encoder.sv
bench/addressable_led_pixel_encoder_tb.sv
